@@ src/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared shorthand for the concurrent checks of the rotation core.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that is switched off while reset is high.
`define BTER_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// Check that also runs through reset.
`define BTER_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) \
      else $error(msg);

`endif

@@ src/bter_pkg.sv @@
// ----------------------------------------------------------------------------
// Body-to-ENU rotation package
// Types, widths, register indexes and fixed-point helpers of the rotation core.
// ----------------------------------------------------------------------------
package bter_pkg;

   typedef enum logic [1:0] {
      KIND_POSITION = 2'd0,
      KIND_ORIENT   = 2'd1,
      KIND_LINVEL   = 2'd2,
      KIND_ANGVEL   = 2'd3
   } kind_type;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ROT_W         = 3'd0,
      CSR_ROT_X         = 3'd1,
      CSR_ROT_Y         = 3'd2,
      CSR_ROT_Z         = 3'd3,
      CSR_LATERAL_LIMIT = 3'd4
   } csr_index_type;

   localparam int DATA_W  = 32;
   localparam int LIMIT_W = 31;
   localparam int Q_FRAC  = 30;
   localparam int PROD1_W = 64;   // Q16.16 times Q2.30
   localparam int PROD2_W = 68;   // t times Q2.30
   localparam int RND_W   = 34;   // rounded first-pass term
   localparam int T_W     = 36;   // unrounded t component
   localparam int TERM_W  = 37;   // rounded second-pass term
   localparam int ACC_W   = 39;   // sum before saturation

   localparam int QW = 0;
   localparam int QX = 1;
   localparam int QY = 2;
   localparam int QZ = 3;

   localparam int NUM_T_PROD = 9;
   localparam int PIPE_DEPTH = 6;
   localparam int OCC_W      = $clog2(PIPE_DEPTH + 1);

   localparam logic signed [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic signed [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

   typedef struct packed {
      logic signed [DATA_W-1:0] w;
      logic signed [DATA_W-1:0] x;
      logic signed [DATA_W-1:0] y;
      logic signed [DATA_W-1:0] z;
      logic [LIMIT_W-1:0]       lateral_limit;
   } cfg_type;

   typedef struct packed {
      kind_type                 kind;
      logic signed [DATA_W-1:0] comp_x;
      logic signed [DATA_W-1:0] comp_y;
      logic signed [DATA_W-1:0] comp_z;
      logic signed [DATA_W-1:0] comp_w;
   } in_item_type;

   // Fields that ride along the back half untouched.
   typedef struct packed {
      kind_type                 kind;
      logic                     keep;
      logic signed [DATA_W-1:0] vx;
      logic signed [DATA_W-1:0] vy;
      logic signed [DATA_W-1:0] vz;
      logic signed [DATA_W-1:0] ow;
      logic signed [DATA_W-1:0] ox;
      logic signed [DATA_W-1:0] oy;
      logic signed [DATA_W-1:0] oz;
   } carry_type;

   typedef struct packed {
      carry_type             c;
      logic signed [T_W-1:0] tx;
      logic signed [T_W-1:0] ty;
      logic signed [T_W-1:0] tz;
   } mid_item_type;

   typedef struct packed {
      kind_type                 kind;
      logic signed [DATA_W-1:0] x;
      logic signed [DATA_W-1:0] y;
      logic signed [DATA_W-1:0] z;
      logic signed [DATA_W-1:0] w;
      logic                     keep;
   } out_item_type;

   // Scale a product by 2^-30, rounding the magnitude to nearest with ties
   // away from zero.
   function automatic logic signed [TERM_W-1:0] rnd_q30(
      input logic signed [PROD2_W-1:0] p
   );
      logic [PROD2_W-1:0]        mag;
      logic [PROD2_W-1:0]        sum;
      logic [PROD2_W-Q_FRAC-1:0] r;
      logic [PROD2_W-Q_FRAC-1:0] rs;
      mag = p[PROD2_W-1] ? (~p + PROD2_W'(1)) : p;
      sum = mag + (PROD2_W'(1) << (Q_FRAC - 1));
      r   = sum[PROD2_W-1:Q_FRAC];
      rs  = p[PROD2_W-1] ? (~r + (PROD2_W-Q_FRAC)'(1)) : r;
      return rs[TERM_W-1:0];
   endfunction

   function automatic logic signed [DATA_W-1:0] sat32(
      input logic signed [ACC_W-1:0] a
   );
      logic [ACC_W-DATA_W:0] hi;
      hi = a[ACC_W-1:DATA_W-1];
      if ((&hi) || !(|hi)) begin
         return a[DATA_W-1:0];
      end else if (a[ACC_W-1]) begin
         return DATA_MIN;
      end else begin
         return DATA_MAX;
      end
   endfunction

endpackage

@@ src/bter_if.sv @@
// ----------------------------------------------------------------------------
// Rotation core channels
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
interface bter_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         req_type;
   logic signed [31:0] comp_x;
   logic signed [31:0] comp_y;
   logic signed [31:0] comp_z;
   logic signed [31:0] comp_w;

   modport source(output valid, req_type, comp_x, comp_y, comp_z, comp_w,
                  input ready);
   modport sink(input valid, req_type, comp_x, comp_y, comp_z, comp_w,
                output ready);
endinterface

interface bter_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         res_kind;
   logic signed [31:0] res_x;
   logic signed [31:0] res_y;
   logic signed [31:0] res_z;
   logic signed [31:0] res_w;
   logic               keep;

   modport source(output valid, res_kind, res_x, res_y, res_z, res_w, keep,
                  input ready);
   modport sink(input valid, res_kind, res_x, res_y, res_z, res_w, keep,
                output ready);
endinterface

@@ src/bter_front.sv @@
// ----------------------------------------------------------------------------
// Rotation core front half
// Products of the input with the rotation quaternion, rounding, the
// orientation product and the t vector, in three register stages.
// ----------------------------------------------------------------------------
module bter_front import bter_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  cfg_type      cfg,
   input  logic         in_valid,
   output logic         in_ready,
   input  in_item_type  in_item,
   output logic         out_valid,
   input  logic         out_ready,
   output mid_item_type out_item
);

   logic adv1, adv2, adv3;
   logic s1_vld_ff, s1_vld_in;
   logic s2_vld_ff, s2_vld_in;
   logic s3_vld_ff, s3_vld_in;

   kind_type                  s1_kind_ff, s1_kind_in;
   logic                      s1_keep_ff, s1_keep_in;
   logic signed [DATA_W-1:0]  s1_vx_ff, s1_vy_ff, s1_vz_ff;
   logic signed [PROD1_W-1:0] s1_prod_ff [4][4];
   logic signed [PROD1_W-1:0] s1_prod_in [4][4];

   kind_type                  s2_kind_ff;
   logic                      s2_keep_ff;
   logic signed [DATA_W-1:0]  s2_vx_ff, s2_vy_ff, s2_vz_ff;
   logic signed [RND_W-1:0]   s2_rt_ff [4][4];
   logic signed [RND_W-1:0]   s2_rt_in [4][4];

   mid_item_type s3_item_ff, s3_item_in;

   logic signed [DATA_W-1:0] va [4];
   logic signed [DATA_W-1:0] qa [4];
   logic [DATA_W-1:0]        mag_y, mag_z;

   // A stage moves when it is empty or its successor moves.
   assign adv3     = !s3_vld_ff || out_ready;
   assign adv2     = !s2_vld_ff || adv3;
   assign adv1     = !s1_vld_ff || adv2;
   assign in_ready = adv1;

   assign s1_vld_in = adv1 ? in_valid  : s1_vld_ff;
   assign s2_vld_in = adv2 ? s1_vld_ff : s2_vld_ff;
   assign s3_vld_in = adv3 ? s2_vld_ff : s3_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= s1_vld_in;
         s2_vld_ff <= s2_vld_in;
         s3_vld_ff <= s3_vld_in;
      end
   end

   // Stage 1: all sixteen products of input part and quaternion part.
   assign va[QW] = in_item.comp_w;
   assign va[QX] = in_item.comp_x;
   assign va[QY] = in_item.comp_y;
   assign va[QZ] = in_item.comp_z;
   assign qa[QW] = cfg.w;
   assign qa[QX] = cfg.x;
   assign qa[QY] = cfg.y;
   assign qa[QZ] = cfg.z;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         for (int j = 0; j < 4; j++) begin
            s1_prod_in[i][j] = PROD1_W'(va[i]) * PROD1_W'(qa[j]);
         end
      end
   end

   // The gate uses exact magnitudes, so the most negative value is 2^31.
   assign mag_y = in_item.comp_y[DATA_W-1] ? (~in_item.comp_y + DATA_W'(1))
                                           : in_item.comp_y;
   assign mag_z = in_item.comp_z[DATA_W-1] ? (~in_item.comp_z + DATA_W'(1))
                                           : in_item.comp_z;
   assign s1_kind_in = in_item.kind;
   assign s1_keep_in = (in_item.kind != KIND_LINVEL) ||
                       ((mag_y <= {1'b0, cfg.lateral_limit}) &&
                        (mag_z <= {1'b0, cfg.lateral_limit}));

   always_ff @(posedge clock) begin
      if (adv1) begin
         s1_kind_ff <= s1_kind_in;
         s1_keep_ff <= s1_keep_in;
         s1_vx_ff   <= in_item.comp_x;
         s1_vy_ff   <= in_item.comp_y;
         s1_vz_ff   <= in_item.comp_z;
         s1_prod_ff <= s1_prod_in;
      end
   end

   // Stage 2: round every product back to Q16.16.
   always_comb begin
      logic signed [TERM_W-1:0] rnd;
      for (int i = 0; i < 4; i++) begin
         for (int j = 0; j < 4; j++) begin
            rnd = rnd_q30(PROD2_W'(s1_prod_ff[i][j]));
            s2_rt_in[i][j] = rnd[RND_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv2) begin
         s2_kind_ff <= s1_kind_ff;
         s2_keep_ff <= s1_keep_ff;
         s2_vx_ff   <= s1_vx_ff;
         s2_vy_ff   <= s1_vy_ff;
         s2_vz_ff   <= s1_vz_ff;
         s2_rt_ff   <= s2_rt_in;
      end
   end

   // Stage 3: Hamilton product q * p, and t = 2 (u x v) for vector items.
   always_comb begin
      logic signed [ACC_W-1:0] sw, sx, sy, sz;
      logic signed [ACC_W-1:0] dx, dy, dz;
      sw = ACC_W'(s2_rt_ff[QW][QW]) - ACC_W'(s2_rt_ff[QX][QX])
         - ACC_W'(s2_rt_ff[QY][QY]) - ACC_W'(s2_rt_ff[QZ][QZ]);
      sx = ACC_W'(s2_rt_ff[QX][QW]) + ACC_W'(s2_rt_ff[QW][QX])
         + ACC_W'(s2_rt_ff[QZ][QY]) - ACC_W'(s2_rt_ff[QY][QZ]);
      sy = ACC_W'(s2_rt_ff[QY][QW]) - ACC_W'(s2_rt_ff[QZ][QX])
         + ACC_W'(s2_rt_ff[QW][QY]) + ACC_W'(s2_rt_ff[QX][QZ]);
      sz = ACC_W'(s2_rt_ff[QZ][QW]) + ACC_W'(s2_rt_ff[QY][QX])
         - ACC_W'(s2_rt_ff[QX][QY]) + ACC_W'(s2_rt_ff[QW][QZ]);
      dx = ACC_W'(s2_rt_ff[QZ][QY]) - ACC_W'(s2_rt_ff[QY][QZ]);
      dy = ACC_W'(s2_rt_ff[QX][QZ]) - ACC_W'(s2_rt_ff[QZ][QX]);
      dz = ACC_W'(s2_rt_ff[QY][QX]) - ACC_W'(s2_rt_ff[QX][QY]);

      s3_item_in.c.kind = s2_kind_ff;
      s3_item_in.c.keep = s2_keep_ff;
      s3_item_in.c.vx   = s2_vx_ff;
      s3_item_in.c.vy   = s2_vy_ff;
      s3_item_in.c.vz   = s2_vz_ff;
      s3_item_in.c.ow   = sat32(sw);
      s3_item_in.c.ox   = sat32(sx);
      s3_item_in.c.oy   = sat32(sy);
      s3_item_in.c.oz   = sat32(sz);
      s3_item_in.tx     = T_W'(dx) <<< 1;
      s3_item_in.ty     = T_W'(dy) <<< 1;
      s3_item_in.tz     = T_W'(dz) <<< 1;
   end

   always_ff @(posedge clock) begin
      if (adv3) begin
         s3_item_ff <= s3_item_in;
      end
   end

   assign out_valid = s3_vld_ff;
   assign out_item  = s3_item_ff;

endmodule

@@ src/bter_back.sv @@
// ----------------------------------------------------------------------------
// Rotation core back half
// Products of t with the rotation quaternion, rounding, and the final sums
// with saturation and result selection, in three register stages.
// ----------------------------------------------------------------------------
module bter_back import bter_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  cfg_type      cfg,
   input  logic         in_valid,
   output logic         in_ready,
   input  mid_item_type in_item,
   output logic         out_valid,
   input  logic         out_ready,
   output out_item_type out_item
);

   logic adv4, adv5, adv6;
   logic s4_vld_ff, s4_vld_in;
   logic s5_vld_ff, s5_vld_in;
   logic s6_vld_ff, s6_vld_in;

   carry_type                 s4_carry_ff;
   logic signed [PROD2_W-1:0] s4_prod_ff [NUM_T_PROD];
   logic signed [PROD2_W-1:0] s4_prod_in [NUM_T_PROD];

   carry_type                 s5_carry_ff;
   logic signed [TERM_W-1:0]  s5_term_ff [NUM_T_PROD];
   logic signed [TERM_W-1:0]  s5_term_in [NUM_T_PROD];

   out_item_type s6_item_ff, s6_item_in;

   logic signed [T_W-1:0]    ta [NUM_T_PROD];
   logic signed [DATA_W-1:0] qa [NUM_T_PROD];

   assign adv6     = !s6_vld_ff || out_ready;
   assign adv5     = !s5_vld_ff || adv6;
   assign adv4     = !s4_vld_ff || adv5;
   assign in_ready = adv4;

   assign s4_vld_in = adv4 ? in_valid  : s4_vld_ff;
   assign s5_vld_in = adv5 ? s4_vld_ff : s5_vld_ff;
   assign s6_vld_in = adv6 ? s5_vld_ff : s6_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_vld_ff <= 1'b0;
         s5_vld_ff <= 1'b0;
         s6_vld_ff <= 1'b0;
      end else begin
         s4_vld_ff <= s4_vld_in;
         s5_vld_ff <= s5_vld_in;
         s6_vld_ff <= s6_vld_in;
      end
   end

   // Three products per output component, grouped so that component c
   // uses entries 3c (plus), 3c+1 (plus) and 3c+2 (minus).
   assign ta[0] = in_item.tx;  assign qa[0] = cfg.w;
   assign ta[1] = in_item.tz;  assign qa[1] = cfg.y;
   assign ta[2] = in_item.ty;  assign qa[2] = cfg.z;
   assign ta[3] = in_item.ty;  assign qa[3] = cfg.w;
   assign ta[4] = in_item.tx;  assign qa[4] = cfg.z;
   assign ta[5] = in_item.tz;  assign qa[5] = cfg.x;
   assign ta[6] = in_item.tz;  assign qa[6] = cfg.w;
   assign ta[7] = in_item.ty;  assign qa[7] = cfg.x;
   assign ta[8] = in_item.tx;  assign qa[8] = cfg.y;

   // Stage 4: products.
   always_comb begin
      for (int k = 0; k < NUM_T_PROD; k++) begin
         s4_prod_in[k] = PROD2_W'(ta[k]) * PROD2_W'(qa[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv4) begin
         s4_carry_ff <= in_item.c;
         s4_prod_ff  <= s4_prod_in;
      end
   end

   // Stage 5: rounding.
   always_comb begin
      for (int k = 0; k < NUM_T_PROD; k++) begin
         s5_term_in[k] = rnd_q30(s4_prod_ff[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv5) begin
         s5_carry_ff <= s4_carry_ff;
         s5_term_ff  <= s5_term_in;
      end
   end

   // Stage 6: v' = v + rot_w t + u x t, then pick the orientation result
   // for orientation items.
   always_comb begin
      logic signed [ACC_W-1:0] ax, ay, az;
      logic                    is_orient;
      ax = ACC_W'(s5_carry_ff.vx) + ACC_W'(s5_term_ff[0])
         + ACC_W'(s5_term_ff[1]) - ACC_W'(s5_term_ff[2]);
      ay = ACC_W'(s5_carry_ff.vy) + ACC_W'(s5_term_ff[3])
         + ACC_W'(s5_term_ff[4]) - ACC_W'(s5_term_ff[5]);
      az = ACC_W'(s5_carry_ff.vz) + ACC_W'(s5_term_ff[6])
         + ACC_W'(s5_term_ff[7]) - ACC_W'(s5_term_ff[8]);
      is_orient = (s5_carry_ff.kind == KIND_ORIENT);

      s6_item_in.kind = s5_carry_ff.kind;
      s6_item_in.keep = s5_carry_ff.keep;
      s6_item_in.x    = is_orient ? s5_carry_ff.ox : sat32(ax);
      s6_item_in.y    = is_orient ? s5_carry_ff.oy : sat32(ay);
      s6_item_in.z    = is_orient ? s5_carry_ff.oz : sat32(az);
      s6_item_in.w    = is_orient ? s5_carry_ff.ow : '0;
   end

   always_ff @(posedge clock) begin
      if (adv6) begin
         s6_item_ff <= s6_item_in;
      end
   end

   assign out_valid = s6_vld_ff;
   assign out_item  = s6_item_ff;

endmodule

@@ src/body_to_enu_quaternion_rotate_core.sv @@
// ----------------------------------------------------------------------------
// Body-to-ENU quaternion rotation core
// Rotates odometry items from the body frame into the east-north-up frame.
// ----------------------------------------------------------------------------
// Each item on the request channel is one odometry quantity in signed Q16.16.
// Position, linear velocity and angular velocity items are rotated as
// 3-vectors by the unit quaternion held in the rot_w..rot_z registers
// (signed Q2.30); orientation items are premultiplied by that quaternion
// (Hamilton product) and return the scalar part in res_w, which is zero for
// every other kind. Every single product is rounded to nearest (ties away
// from zero) back to Q16.16, and each result component saturates to 32 bits.
// For linear-velocity items the keep flag reports whether the body-frame y
// and z magnitudes are both within lateral_limit; it is 1 for other kinds.
// The core is a six-stage pipeline and takes one item every clock cycle
// while the result channel is not stalled. The depth comes from the two
// multiply passes (input times quaternion, then t times quaternion), each
// split into a multiply stage, a rounding stage and a summing stage. Every
// stage has its own valid bit and moves whenever it is empty or its
// successor moves, so a stalled result channel fills the empty stages
// before the request channel sees ready low. Configuration registers are
// written through the csr_ port and must only change while no item is in
// flight.
`include "assert_macros.svh"

module body_to_enu_quaternion_rotate_core import bter_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   bter_req_if.sink              req_if,
   bter_rsp_if.source            rsp_if,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type      cfg_ff, cfg_in;
   in_item_type  req_item;
   mid_item_type mid_item;
   out_item_type rsp_item;
   logic         mid_valid, mid_ready;
   logic [OCC_W-1:0] occ_ff, occ_in;

   // Configuration registers. Indexes past the last register are dropped.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_ROT_W:         cfg_in.w = csr_wdata;
            CSR_ROT_X:         cfg_in.x = csr_wdata;
            CSR_ROT_Y:         cfg_in.y = csr_wdata;
            CSR_ROT_Z:         cfg_in.z = csr_wdata;
            CSR_LATERAL_LIMIT: cfg_in.lateral_limit = csr_wdata[LIMIT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Reset leaves the identity rotation and a limit of about 0.1.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.w             <= 32'sd1073741824;
         cfg_ff.x             <= '0;
         cfg_ff.y             <= '0;
         cfg_ff.z             <= '0;
         cfg_ff.lateral_limit <= 31'd6554;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_item.kind   = kind_type'(req_if.req_type);
   assign req_item.comp_x = req_if.comp_x;
   assign req_item.comp_y = req_if.comp_y;
   assign req_item.comp_z = req_if.comp_z;
   assign req_item.comp_w = req_if.comp_w;

   // Stages one to three: first products, rounding, orientation and t.
   bter_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (req_if.valid),
      .in_ready  (req_if.ready),
      .in_item   (req_item),
      .out_valid (mid_valid),
      .out_ready (mid_ready),
      .out_item  (mid_item)
   );

   // Stages four to six: second products, rounding, final sums.
   bter_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (mid_valid),
      .in_ready  (mid_ready),
      .in_item   (mid_item),
      .out_valid (rsp_if.valid),
      .out_ready (rsp_if.ready),
      .out_item  (rsp_item)
   );

   assign rsp_if.res_kind = rsp_item.kind;
   assign rsp_if.res_x    = rsp_item.x;
   assign rsp_if.res_y    = rsp_item.y;
   assign rsp_if.res_z    = rsp_item.z;
   assign rsp_if.res_w    = rsp_item.w;
   assign rsp_if.keep     = rsp_item.keep;

   // Number of items inside the pipeline, used by the checks below.
   assign occ_in = occ_ff + OCC_W'(req_if.valid && req_if.ready)
                          - OCC_W'(rsp_if.valid && rsp_if.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   `BTER_ASSERT(a_keep_only_linvel, clock, reset, (rsp_if.valid && rsp_if.res_kind != KIND_LINVEL) |-> rsp_if.keep, "keep cleared on a kind other than linear velocity")
   `BTER_ASSERT(a_w_zero_vector, clock, reset, (rsp_if.valid && rsp_if.res_kind != KIND_ORIENT) |-> (rsp_if.res_w == '0), "res_w nonzero on a vector item")
   `BTER_ASSERT(a_occ_bound, clock, reset, (occ_ff <= OCC_W'(PIPE_DEPTH)) && ((occ_ff != '0) || !rsp_if.valid), "pipeline holds more items than stages, or shows a result it never took")
   `BTER_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_if.valid, "result shown right after reset")

endmodule

@@ test/body_to_enu_quaternion_rotate_core_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Body-to-ENU rotation core testbench
// Sends position, orientation and velocity items through the rotation core
// and checks every result against a typed-in value or a fixed-point predictor in the bench.
// The run starts with a scripted sequence of items and register writes, then
// eight random phases, each with its own rotation setting and one of four idling patterns.
// ----------------------------------------------------------------------------
module body_to_enu_quaternion_rotate_core_test;
   import bter_pkg::*;

   // One unit in Q2.30, and cos(45 degrees) in Q2.30 for a quarter turn.
   localparam logic signed [DATA_W-1:0] ROT_ONE = 32'sd1073741824;
   localparam logic signed [DATA_W-1:0] COS45  = 32'sd759250125;
   // Reset value of the lateral limit, about 0.1 in Q16.16.
   localparam logic [LIMIT_W-1:0] LIMIT_DEFAULT = 31'd6554;
   // First register index past the register map; writes to it must be dropped.
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED = 3'd5;

   localparam int NUM_PHASES      = 8;
   localparam int ITEMS_PER_PHASE = 229;
   localparam int CYCLE_LIMIT     = 400000;

   // One step of the scripted opening: either a register write or an item.
   // Where the result can be read off at a glance it is typed in (known = 1);
   // otherwise the predictor supplies it.
   typedef struct packed {
      logic                  is_write;
      logic [CSR_IDX_W-1:0]  index;
      logic [CSR_DATA_W-1:0] data;
      in_item_type           item;
      logic                  known;
      out_item_type          want;
   } script_row_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   bter_req_if req_if ();
   bter_rsp_if rsp_if ();

   // Register contents as the predictor sees them.
   cfg_type        active_cfg;
   // Results still owed by the core, oldest first.
   out_item_type   pending_rotations[$];
   script_row_type script[$];

   int mismatches    = 0;
   int cycles        = 0;
   int send_gap_pct  = 0;
   int rsp_stall_pct = 0;

   body_to_enu_quaternion_rotate_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .rsp_if    (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------

   // Exact product of a Q16.16 quantity and a Q2.30 quaternion part, scaled
   // back to Q16.16 with the magnitude rounded half away from zero.
   function automatic longint scale_q30(input longint a, input longint q);
      logic [127:0] prod;
      longint       ma;
      longint       mq;
      longint       mag;
      ma   = (a < 0) ? -a : a;
      mq   = (q < 0) ? -q : q;
      prod = 128'(ma) * 128'(mq) + (128'd1 << (Q_FRAC - 1));
      mag  = longint'(prod >> Q_FRAC);
      return ((a < 0) != (q < 0)) ? -mag : mag;
   endfunction

   function automatic logic signed [DATA_W-1:0] clamp_q16(input longint v);
      if (v > longint'(DATA_MAX)) begin
         return DATA_MAX;
      end else if (v < longint'(DATA_MIN)) begin
         return DATA_MIN;
      end
      return v[DATA_W-1:0];
   endfunction

   // Vectors go through v' = v + w t + u x t with t = 2 (u x v); orientation
   // quaternions are premultiplied by the rotation (Hamilton product). The
   // rotation is used as written, with no normalization.
   function automatic out_item_type predict_rotation(input in_item_type it,
                                                     input cfg_type c);
      out_item_type r;
      longint vx, vy, vz, vw;
      longint qw, qx, qy, qz;
      longint tx, ty, tz;
      longint ay, az;
      vx = it.comp_x;
      vy = it.comp_y;
      vz = it.comp_z;
      vw = it.comp_w;
      qw = c.w;
      qx = c.x;
      qy = c.y;
      qz = c.z;
      r.kind = it.kind;
      r.keep = 1'b1;
      if (it.kind == KIND_ORIENT) begin
         r.w = clamp_q16(scale_q30(vw, qw) - scale_q30(vx, qx)
                         - scale_q30(vy, qy) - scale_q30(vz, qz));
         r.x = clamp_q16(scale_q30(vx, qw) + scale_q30(vw, qx)
                         + scale_q30(vz, qy) - scale_q30(vy, qz));
         r.y = clamp_q16(scale_q30(vy, qw) - scale_q30(vz, qx)
                         + scale_q30(vw, qy) + scale_q30(vx, qz));
         r.z = clamp_q16(scale_q30(vz, qw) + scale_q30(vy, qx)
                         - scale_q30(vx, qy) + scale_q30(vw, qz));
      end else begin
         tx = 2 * (scale_q30(vz, qy) - scale_q30(vy, qz));
         ty = 2 * (scale_q30(vx, qz) - scale_q30(vz, qx));
         tz = 2 * (scale_q30(vy, qx) - scale_q30(vx, qy));
         r.x = clamp_q16(vx + scale_q30(tx, qw) + scale_q30(tz, qy) - scale_q30(ty, qz));
         r.y = clamp_q16(vy + scale_q30(ty, qw) + scale_q30(tx, qz) - scale_q30(tz, qx));
         r.z = clamp_q16(vz + scale_q30(tz, qw) + scale_q30(ty, qx) - scale_q30(tx, qy));
         r.w = '0;
         // The lateral gate looks at the body-frame input; the magnitude of
         // the most negative value is a full 2^31.
         if (it.kind == KIND_LINVEL) begin
            ay = (vy < 0) ? -vy : vy;
            az = (vz < 0) ? -vz : vz;
            r.keep = (ay <= longint'(c.lateral_limit)) && (az <= longint'(c.lateral_limit));
         end
      end
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------

   // Mix of full-range words, the edges of the range, moderate values and
   // values right at the lateral limit so the keep gate flips both ways.
   function automatic logic signed [DATA_W-1:0] pick_component(input longint edge_val);
      longint m;
      case ($urandom_range(9))
         0: begin
            case ($urandom_range(3))
               0:       m = longint'(DATA_MAX);
               1:       m = longint'(DATA_MIN);
               2:       m = 0;
               default: m = -1;
            endcase
         end
         1, 2: m = longint'($signed($urandom()));
         3, 4, 5, 6: m = longint'($urandom_range(32'h0800_0000)) - 64'h0400_0000;
         default: begin
            m = edge_val + longint'($urandom_range(2)) - 1;
            if ($urandom_range(1) == 1) m = -m;
            if (m > longint'(DATA_MAX)) m = longint'(DATA_MAX);
         end
      endcase
      return m[DATA_W-1:0];
   endfunction

   function automatic in_item_type random_request(input longint edge_val);
      in_item_type it;
      it.kind   = kind_type'(2'($urandom_range(3)));
      it.comp_x = pick_component(edge_val);
      it.comp_y = pick_component(edge_val);
      it.comp_z = pick_component(edge_val);
      it.comp_w = pick_component(edge_val);
      return it;
   endfunction

   // Random rotation scaled to unit length in Q2.30.
   function automatic cfg_type unit_rotation(input logic [LIMIT_W-1:0] limit);
      cfg_type c;
      real     a[4];
      real     n;
      n = 0.0;
      for (int i = 0; i < 4; i++) begin
         a[i] = real'(int'($urandom_range(2000)) - 1000) + 0.5;
         n    = n + a[i] * a[i];
      end
      n = $sqrt(n);
      c.w = 32'($rtoi(a[0] / n * 1073741824.0));
      c.x = 32'($rtoi(a[1] / n * 1073741824.0));
      c.y = 32'($rtoi(a[2] / n * 1073741824.0));
      c.z = 32'($rtoi(a[3] / n * 1073741824.0));
      c.lateral_limit = limit;
      return c;
   endfunction

   // Register setting for each random phase. The list walks through the
   // reset values, a clean quarter turn, random unit rotations and the
   // non-unit extremes (all maximum, all minimum, all zero, raw words), with
   // the lateral limit at zero, at its maximum and in between.
   function automatic cfg_type phase_setting(input int phase);
      cfg_type c;
      case (phase)
         0: c = '{w: ROT_ONE, x: '0, y: '0, z: '0, lateral_limit: LIMIT_DEFAULT};
         1: c = '{w: COS45, x: '0, y: '0, z: COS45,
                  lateral_limit: 31'($urandom_range(32'h0010_0000))};
         2: c = unit_rotation('0);
         3: c = '{w: DATA_MAX, x: DATA_MAX, y: DATA_MAX, z: DATA_MAX,
                  lateral_limit: '1};
         4: c = '{w: DATA_MIN, x: DATA_MIN, y: DATA_MIN, z: DATA_MIN,
                  lateral_limit: 31'($urandom())};
         5: c = '{w: '0, x: '0, y: '0, z: '0,
                  lateral_limit: 31'($urandom_range(32'h0001_0000))};
         6: c = '{w: $urandom(), x: $urandom(), y: $urandom(), z: $urandom(),
                  lateral_limit: 31'($urandom())};
         default: c = unit_rotation(LIMIT_DEFAULT);
      endcase
      return c;
   endfunction

   // A register write raises the enable, then drops it again before returning,
   // so that back-to-back writes never retarget the enable twice in one step.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      case (index)
         CSR_ROT_W:         active_cfg.w = data;
         CSR_ROT_X:         active_cfg.x = data;
         CSR_ROT_Y:         active_cfg.y = data;
         CSR_ROT_Z:         active_cfg.z = data;
         CSR_LATERAL_LIMIT: active_cfg.lateral_limit = data[LIMIT_W-1:0];
         default: ;
      endcase
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // Loads a full setting. The limit goes out with a random top bit that the
   // core has to drop, and a write to the unmapped index must change nothing.
   task automatic load_rotation(input cfg_type c);
      write_reg(CSR_ROT_W, c.w);
      write_reg(CSR_ROT_X, c.x);
      write_reg(CSR_ROT_Y, c.y);
      write_reg(CSR_ROT_Z, c.z);
      write_reg(CSR_LATERAL_LIMIT, {1'($urandom_range(1)), c.lateral_limit});
      write_reg(CSR_UNMAPPED, $urandom());
   endtask

   // Holds the request channel quiet until every owed result has come back.
   // Every item yields exactly one result, so an empty queue means the
   // pipeline is empty as well.
   task automatic settle();
      if (pending_rotations.size() != 0) begin
         req_if.valid <= 1'b0;
         while (pending_rotations.size() != 0) @(posedge clock);
      end
   endtask

   // Offers one item, after a random gap. The handshake is judged at the
   // falling edge, where valid and ready have settled; the item is then taken
   // at the next rising edge, and its expected result is queued.
   task automatic send_item(input in_item_type it, input logic known,
                            input out_item_type want);
      while ($urandom_range(99) < send_gap_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid    <= 1'b1;
      req_if.req_type <= it.kind;
      req_if.comp_x   <= it.comp_x;
      req_if.comp_y   <= it.comp_y;
      req_if.comp_z   <= it.comp_z;
      req_if.comp_w   <= it.comp_w;
      @(negedge clock);
      while (!req_if.ready) @(negedge clock);
      pending_rotations.push_back(known ? want : predict_rotation(it, active_cfg));
      @(posedge clock);
   endtask

   task automatic script_item(input kind_type k,
                              input logic signed [DATA_W-1:0] x, y, z, w,
                              input logic known,
                              input logic signed [DATA_W-1:0] ex, ey, ez, ew,
                              input logic ekeep);
      script_row_type r;
      r          = '0;
      r.item     = '{kind: k, comp_x: x, comp_y: y, comp_z: z, comp_w: w};
      r.known    = known;
      r.want     = '{kind: k, x: ex, y: ey, z: ez, w: ew, keep: ekeep};
      script.push_back(r);
   endtask

   task automatic script_write(input logic [CSR_IDX_W-1:0] index,
                               input logic [CSR_DATA_W-1:0] data);
      script_row_type r;
      r          = '0;
      r.is_write = 1'b1;
      r.index    = index;
      r.data     = data;
      script.push_back(r);
   endtask

   // ---------------------------------------------------------------------
   // Result side
   // ---------------------------------------------------------------------

   // Result ready is redrawn at every rising edge according to the stall rate
   // of the current phase.
   initial begin
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_if.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // A result is taken at the rising edge that follows a falling edge with
   // valid and ready both high; it is compared here, field by field, with the
   // oldest owed result.
   always @(negedge clock) begin
      out_item_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_rotations.size() == 0) begin
            $error("result with no item outstanding: kind %0d x %0d y %0d z %0d",
                   rsp_if.res_kind, rsp_if.res_x, rsp_if.res_y, rsp_if.res_z);
            mismatches++;
         end else begin
            want = pending_rotations.pop_front();
            if (rsp_if.res_kind !== want.kind) begin
               $error("res_kind: expected %0d, got %0d", want.kind, rsp_if.res_kind);
               mismatches++;
            end
            if (rsp_if.res_x !== want.x) begin
               $error("res_x: expected %0d, got %0d", want.x, rsp_if.res_x);
               mismatches++;
            end
            if (rsp_if.res_y !== want.y) begin
               $error("res_y: expected %0d, got %0d", want.y, rsp_if.res_y);
               mismatches++;
            end
            if (rsp_if.res_z !== want.z) begin
               $error("res_z: expected %0d, got %0d", want.z, rsp_if.res_z);
               mismatches++;
            end
            if (rsp_if.res_w !== want.w) begin
               $error("res_w: expected %0d, got %0d", want.w, rsp_if.res_w);
               mismatches++;
            end
            if (rsp_if.keep !== want.keep) begin
               $error("keep: expected %0d, got %0d", want.keep, rsp_if.keep);
               mismatches++;
            end
         end
      end
   end

   // Guard against a hung handshake.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      reset           <= 1'b1;
      csr_we          <= 1'b0;
      csr_index       <= '0;
      csr_wdata       <= '0;
      req_if.valid    <= 1'b0;
      req_if.req_type <= '0;
      req_if.comp_x   <= '0;
      req_if.comp_y   <= '0;
      req_if.comp_z   <= '0;
      req_if.comp_w   <= '0;
      active_cfg = '{w: ROT_ONE, x: '0, y: '0, z: '0, lateral_limit: LIMIT_DEFAULT};

      // Out of reset the rotation is the identity, so every item comes back
      // unchanged, orientation scalar included, and non-orientation items
      // carry a zero scalar whatever comp_w held.
      script_item(KIND_POSITION, 0, 0, 0, 32'sh1234_5678, 1, 0, 0, 0, 0, 1);
      script_item(KIND_POSITION, DATA_MAX, DATA_MIN, 1, 0,
                  1, DATA_MAX, DATA_MIN, 1, 0, 1);
      script_item(KIND_ORIENT, 1, -1, DATA_MAX, DATA_MIN,
                  1, 1, -1, DATA_MAX, DATA_MIN, 1);
      script_item(KIND_ORIENT, 0, 0, 0, 65536, 1, 0, 0, 0, 65536, 1);
      // Lateral gate at its reset limit: exactly at the limit passes, one
      // past it fails, and the most negative value counts as 2^31.
      script_item(KIND_LINVEL, 100, 6554, -6554, 7, 1, 100, 6554, -6554, 0, 1);
      script_item(KIND_LINVEL, 0, 6555, 0, 0, 1, 0, 6555, 0, 0, 0);
      script_item(KIND_LINVEL, 0, 0, -6555, 0, 1, 0, 0, -6555, 0, 0);
      script_item(KIND_LINVEL, 0, DATA_MIN, 0, 0, 1, 0, DATA_MIN, 0, 0, 0);
      // Angular velocity is never gated, however large its lateral part.
      script_item(KIND_ANGVEL, 5, DATA_MIN, DATA_MAX, -1,
                  1, 5, DATA_MIN, DATA_MAX, 0, 1);

      // Half turn about x: vectors map to (x, -y, -z), so negating the most
      // negative word has to saturate. Orientation maps to (-x, w, -z, y).
      script_write(CSR_ROT_W, '0);
      script_write(CSR_ROT_X, ROT_ONE);
      script_write(CSR_LATERAL_LIMIT, '0);
      script_item(KIND_POSITION, 3, DATA_MIN, DATA_MAX, 0,
                  1, 3, DATA_MAX, -DATA_MAX, 0, 1);
      script_item(KIND_ORIENT, 7, DATA_MIN, 9, 11, 1, 11, -9, DATA_MIN, -7, 1);
      script_item(KIND_ORIENT, DATA_MIN, 0, 0, DATA_MIN,
                  1, DATA_MIN, 0, 0, DATA_MAX, 1);
      // With a zero limit only an exactly zero lateral and vertical speed passes.
      script_item(KIND_LINVEL, 1, 0, 0, 0, 1, 1, 0, 0, 0, 1);
      script_item(KIND_LINVEL, 1, 1, 0, 0, 1, 1, -1, 0, 0, 0);
      script_item(KIND_LINVEL, 0, 0, -1, 0, 1, 0, 0, 1, 0, 0);

      // Largest limit, written with the unused top bit set. The unmapped
      // index is written with zero while rot_x is one, so a decode that
      // aliases it onto a real register shows up in the next items.
      script_write(CSR_LATERAL_LIMIT, '1);
      script_write(CSR_UNMAPPED, '0);
      script_item(KIND_LINVEL, 0, DATA_MAX, DATA_MIN + 1, 0,
                  1, 0, DATA_MIN + 1, DATA_MAX, 0, 1);
      script_item(KIND_LINVEL, 0, DATA_MIN, 0, 0, 1, 0, DATA_MAX, 0, 0, 0);
      script_item(KIND_LINVEL, 0, 0, DATA_MIN, 0, 1, 0, 0, DATA_MAX, 0, 0);

      // Quarter turn about z: the rounding is no longer trivial, so these
      // rows go through the predictor.
      script_write(CSR_ROT_W, COS45);
      script_write(CSR_ROT_X, '0);
      script_write(CSR_ROT_Z, COS45);
      script_write(CSR_LATERAL_LIMIT, LIMIT_DEFAULT);
      script_item(KIND_POSITION, 65536, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      script_item(KIND_ORIENT, 1000, -2000, 3000, 65536, 0, 0, 0, 0, 0, 0);
      script_item(KIND_ANGVEL, -65536, 131072, DATA_MIN, 0, 0, 0, 0, 0, 0, 0);
      script_item(KIND_LINVEL, 12345, 6554, -6554, 0, 0, 0, 0, 0, 0, 0);
      script_item(KIND_LINVEL, DATA_MAX, -6555, 0, 0, 0, 0, 0, 0, 0, 0);

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Scripted opening. Registers change only once the core has gone idle.
      foreach (script[i]) begin
         if (script[i].is_write) begin
            settle();
            write_reg(script[i].index, script[i].data);
         end else begin
            send_item(script[i].item, script[i].known, script[i].want);
         end
      end

      // Random phases. Each loads a new setting with the core idle, and the phases
      // cycle through the idling patterns: none, sender gaps, result stalls,
      // and both at once. Now and then the sender waits for the core to
      // drain completely before going on.
      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         settle();
         load_rotation(phase_setting(phase));
         case (phase % 4)
            0: begin send_gap_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_gap_pct = 46; rsp_stall_pct = 0;  end
            2: begin send_gap_pct = 0;  rsp_stall_pct = 46; end
            default: begin send_gap_pct = 29; rsp_stall_pct = 29; end
         endcase
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if ($urandom_range(99) == 0) settle();
            send_item(random_request(longint'(active_cfg.lateral_limit)), 1'b0, '0);
         end
      end

      // Wait for the last results, then keep watching the result channel to
      // catch any stray result the core might still put out.
      settle();
      repeat (4 * PIPE_DEPTH) @(posedge clock);
      if (mismatches == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
